// ----- hw/rtl/tpfm_pkg.sv -----
package tpfm_pkg;

    // Field and register widths
    localparam int TIME_W     = 32;
    localparam int FREQ_W     = 20;
    localparam int RPM_W      = 16;
    localparam int RPP_W      = 10;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int PROD_W     = FREQ_W + RPP_W;

    // Default ring depth
    localparam int RING_SLOTS_DEF = 5;

    // Fixed constants
    localparam logic [FREQ_W-1:0] FREQ_FULL = 20'd1000000;
    localparam logic [RPM_W-1:0]  RPM_MAX   = 16'hFFFF;

    // Register reset values
    localparam logic [RPP_W-1:0]  RPP_RST          = 10'd30;
    localparam logic [TIME_W-1:0] IDLE_TIMEOUT_RST = 32'd1000000;
    localparam logic [TIME_W-1:0] MAX_INTERVAL_RST = 32'd10000000;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RPM_PER_PULSE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT_US = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_INTERVAL_US = 2'd2;

    // Input kinds
    localparam logic KIND_PULSE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_STALE,
        S_SCAN,
        S_AVG_SETUP,
        S_DIV_AVG,
        S_FREQ_SETUP,
        S_DIV_FREQ,
        S_JITTER,
        S_RPM,
        S_OUT
    } tpfm_state_t;

endpackage

// ----- hw/rtl/tach_pulse_frequency_meter_top.sv -----
// Items: a pulse item is recorded in the idle state and gives no result; a full read
//   scans the ring, then runs two divisions (average period, then frequency) on one
//   shared bit-serial restoring divider before raising its result; a stale read skips
//   the scan and the divisions, and a read with no valid spacing skips the divisions.
// Throughput: one item at a time; pulses back to back, reads one per result taken.
// Reset (rst_n, async, active low): ring and pointers zero, stale limit 1000000,
//   held frequency zero, registers at their defaults, no result pending.
module tach_pulse_frequency_meter_top #(
    parameter int RING_SLOTS = tpfm_pkg::RING_SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // input item channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           kind,
    input  logic [tpfm_pkg::TIME_W-1:0]    time_us,
    // result item channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [tpfm_pkg::FREQ_W-1:0]    freq_hz,
    output logic [tpfm_pkg::RPM_W-1:0]     engine_rpm,
    // configuration write port
    input  logic                           cfg_wr_en,
    input  logic [tpfm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tpfm_pkg::CFG_W-1:0]     cfg_data
);
    import tpfm_pkg::*;

    localparam int SLOT_W = $clog2(RING_SLOTS);
    // sum of up to RING_SLOTS-1 differences of TIME_W bits
    localparam int SUM_W  = TIME_W + SLOT_W;
    localparam int CNT_W  = $clog2(SUM_W + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_SLOTS - 1);

    // configuration registers
    logic [RPP_W-1:0]  rpp_reg;
    logic [TIME_W-1:0] idle_timeout_reg;
    logic [TIME_W-1:0] max_interval_reg;

    // persistent state
    logic [TIME_W-1:0] ring_reg [RING_SLOTS];
    logic [SLOT_W-1:0] write_slot_reg, write_slot_next;
    logic [SLOT_W-1:0] seen_slot_reg, seen_slot_next;
    logic [TIME_W-1:0] stale_limit_reg, stale_limit_next;
    logic [FREQ_W-1:0] held_freq_reg, held_freq_next;

    // sequencer and working registers
    tpfm_state_t       state_reg, state_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic [TIME_W-1:0] prev_reg, prev_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [SLOT_W-1:0] count_reg, count_next;

    // shared divider: dividend/quotient shift register, remainder, divisor, step count
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [TIME_W-1:0] rem_reg, rem_next;
    logic [TIME_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]  step_reg, step_next;

    // result registers
    logic [FREQ_W-1:0] freq_reg, freq_next;
    logic [RPM_W-1:0]  rpm_reg, rpm_next;
    logic              out_valid_reg, out_valid_next;

    // ring write on an accepted pulse
    logic              ring_we;

    // combinational helpers
    logic [SLOT_W-1:0] rd_addr;
    logic [TIME_W-1:0] rd_data;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] diff;
    logic [TIME_W:0]   rem_shift;
    logic [TIME_W:0]   rem_trial;
    logic              rem_ge;
    logic [SUM_W-1:0]  quo_step;
    logic [TIME_W-1:0] rem_step;
    logic [PROD_W-1:0] product;

    // One read port on the ring: the write slot for the stale check, else the scan index.
    assign rd_addr = (state_reg == S_SCAN) ? idx_reg : write_slot_reg;
    assign rd_data = ring_reg[rd_addr];
    assign elapsed = now_reg - rd_data;
    assign diff    = rd_data - prev_reg;

    // One restoring step: shift the next dividend bit in, subtract if it fits.
    assign rem_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, dvs_reg};
    assign rem_trial = rem_shift - {1'b0, dvs_reg};
    assign rem_step  = rem_ge ? rem_trial[TIME_W-1:0] : rem_shift[TIME_W-1:0];
    assign quo_step  = {quo_reg[SUM_W-2:0], rem_ge};

    assign product = PROD_W'(freq_reg) * PROD_W'(rpp_reg);

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign freq_hz    = freq_reg;
    assign engine_rpm = rpm_reg;

    // Configuration writes: unknown indexes drop silently.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rpp_reg          <= RPP_RST;
            idle_timeout_reg <= IDLE_TIMEOUT_RST;
            max_interval_reg <= MAX_INTERVAL_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_RPM_PER_PULSE:   rpp_reg          <= cfg_data[RPP_W-1:0];
                REG_IDLE_TIMEOUT_US: idle_timeout_reg <= cfg_data[TIME_W-1:0];
                REG_MAX_INTERVAL_US: max_interval_reg <= cfg_data[TIME_W-1:0];
                default:             ;
            endcase
        end
    end

    // Timestamp ring: written only by pulse items in the idle state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RING_SLOTS; i++)
            begin
                ring_reg[i] <= '0;
            end
        end
        else if (ring_we)
        begin
            ring_reg[write_slot_reg] <= time_us;
        end
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control and persistent state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_slot_reg  <= '0;
            seen_slot_reg   <= '0;
            stale_limit_reg <= IDLE_TIMEOUT_RST;
            held_freq_reg   <= '0;
            idx_reg         <= '0;
            step_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            write_slot_reg  <= write_slot_next;
            seen_slot_reg   <= seen_slot_next;
            stale_limit_reg <= stale_limit_next;
            held_freq_reg   <= held_freq_next;
            idx_reg         <= idx_next;
            step_reg        <= step_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Working and result data
    always_ff @(posedge clk)
    begin
        now_reg   <= now_next;
        prev_reg  <= prev_next;
        sum_reg   <= sum_next;
        count_reg <= count_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        dvs_reg   <= dvs_next;
        freq_reg  <= freq_next;
        rpm_reg   <= rpm_next;
    end

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        write_slot_next  = write_slot_reg;
        seen_slot_next   = seen_slot_reg;
        stale_limit_next = stale_limit_reg;
        held_freq_next   = held_freq_reg;
        now_next         = now_reg;
        idx_next         = idx_reg;
        prev_next        = prev_reg;
        sum_next         = sum_reg;
        count_next       = count_reg;
        quo_next         = quo_reg;
        rem_next         = rem_reg;
        dvs_next         = dvs_reg;
        step_next        = step_reg;
        freq_next        = freq_reg;
        rpm_next         = rpm_reg;
        out_valid_next   = out_valid_reg;
        ring_we          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (kind == KIND_PULSE)
                    begin
                        // record and advance, no result
                        ring_we = 1'b1;
                        write_slot_next = (write_slot_reg == LAST_SLOT) ? '0
                                        : write_slot_reg + 1'b1;
                    end
                    else
                    begin
                        now_next   = time_us;
                        state_next = S_STALE;
                    end
                end
            end

            S_STALE:
            begin
                idx_next   = '0;
                sum_next   = '0;
                count_next = '0;
                state_next = S_SCAN;
                if (write_slot_reg == seen_slot_reg)
                begin
                    if (elapsed > stale_limit_reg)
                    begin
                        // no pulse since last read and too long ago: report zero
                        stale_limit_next = elapsed;
                        held_freq_next   = '0;
                        freq_next        = '0;
                        state_next       = S_RPM;
                    end
                    else
                    begin
                        stale_limit_next = idle_timeout_reg;
                    end
                end
                if (state_next == S_SCAN)
                begin
                    seen_slot_next = write_slot_reg;
                end
            end

            S_SCAN:
            begin
                // walk the ring in slot order; the wrap-around pair is skipped
                prev_next = rd_data;
                if (idx_reg != '0 && diff <= max_interval_reg)
                begin
                    sum_next   = sum_reg + SUM_W'(diff);
                    count_next = count_reg + 1'b1;
                end
                if (idx_reg == LAST_SLOT)
                begin
                    state_next = S_AVG_SETUP;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_AVG_SETUP:
            begin
                if (count_reg == '0)
                begin
                    held_freq_next = '0;
                    freq_next      = '0;
                    state_next     = S_RPM;
                end
                else
                begin
                    quo_next   = sum_reg;
                    rem_next   = '0;
                    dvs_next   = TIME_W'(count_reg);
                    step_next  = CNT_W'(SUM_W);
                    state_next = S_DIV_AVG;
                end
            end

            S_DIV_AVG:
            begin
                quo_next  = quo_step;
                rem_next  = rem_step;
                step_next = step_reg - 1'b1;
                if (step_reg == CNT_W'(1))
                begin
                    state_next = S_FREQ_SETUP;
                end
            end

            S_FREQ_SETUP:
            begin
                // quotient holds the average period in its low bits
                if (quo_reg[TIME_W-1:0] == '0)
                begin
                    freq_next  = FREQ_FULL;
                    state_next = S_JITTER;
                end
                else
                begin
                    // align the constant at the top so only FREQ_W steps are needed
                    quo_next   = {FREQ_FULL, {(SUM_W-FREQ_W){1'b0}}};
                    rem_next   = '0;
                    dvs_next   = quo_reg[TIME_W-1:0];
                    step_next  = CNT_W'(FREQ_W);
                    state_next = S_DIV_FREQ;
                end
            end

            S_DIV_FREQ:
            begin
                quo_next  = quo_step;
                rem_next  = rem_step;
                step_next = step_reg - 1'b1;
                if (step_reg == CNT_W'(1))
                begin
                    freq_next  = quo_step[FREQ_W-1:0];
                    state_next = S_JITTER;
                end
            end

            S_JITTER:
            begin
                // a one-hertz drop keeps the old value; anything else takes the new one
                if (held_freq_reg > freq_reg && held_freq_reg - freq_reg == FREQ_W'(1))
                begin
                    freq_next = held_freq_reg;
                end
                else
                begin
                    held_freq_next = freq_reg;
                end
                state_next = S_RPM;
            end

            S_RPM:
            begin
                rpm_next       = (|product[PROD_W-1:RPM_W]) ? RPM_MAX
                               : product[RPM_W-1:0];
                out_valid_next = 1'b1;
                state_next     = S_OUT;
            end

            S_OUT:
            begin
                // hold the result until taken
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The write pointer never leaves the ring.
    assert property (@(posedge clk) disable iff (!rst_n)
        write_slot_reg <= LAST_SLOT)
        else $error("write slot out of range");

    // A pending result keeps the input side closed.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while a result is pending");

    // A reported frequency never exceeds full scale.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> freq_hz <= FREQ_FULL)
        else $error("frequency above full scale");

    // Zero frequency must report zero rpm.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && freq_hz == '0) |-> engine_rpm == '0)
        else $error("rpm nonzero at zero frequency");

    // A pulse item advances the write pointer by exactly one slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && kind == KIND_PULSE) |=>
            (write_slot_reg == $past(write_slot_reg) + 1'b1 ||
             (write_slot_reg == '0 && $past(write_slot_reg) == LAST_SLOT)))
        else $error("write slot did not advance");

endmodule
